@@ sv/stt_pkg.sv @@
// ============================================================================
// stt_pkg: shared types and constants for the source text tokenizer
// Beat payload structs, token kinds, error codes and scan modes.
// ============================================================================
package stt_pkg;

	localparam int MaxCommentDepth = 15;
	localparam int FractionDigitsKept = 9;
	localparam logic [23:0] LineTop = 24'hFFFFFF;
	localparam logic [15:0] ColTop = 16'hFFFF;

	typedef enum logic [5:0] {
		K_NONE = 6'd0, K_AT = 6'd1, K_HASH = 6'd2, K_COMMA = 6'd3, K_COLON = 6'd4,
		K_DOT = 6'd5, K_SEMI = 6'd6, K_NOT = 6'd8, K_LPAREN = 6'd9, K_RPAREN = 6'd10,
		K_LBRACKET = 6'd11, K_RBRACKET = 6'd12, K_LBRACE = 6'd13, K_RBRACE = 6'd14,
		K_PLUS = 6'd15, K_MINUS = 6'd16, K_STAR = 6'd17, K_SLASH = 6'd18, K_LOR = 6'd19,
		K_LAND = 6'd20, K_CARET = 6'd21, K_PERCENT = 6'd22, K_AMP = 6'd23, K_BAR = 6'd24,
		K_RANGE = 6'd25, K_ELLIPSIS = 6'd26, K_ARROW = 6'd27, K_FATARROW = 6'd28,
		K_LT = 6'd29, K_LTE = 6'd30, K_GT = 6'd31, K_GTE = 6'd32, K_EQ = 6'd33,
		K_NEQ = 6'd34, K_ASSIGN = 6'd35, K_PLUS_A = 6'd36, K_MINUS_A = 6'd37,
		K_BAR_A = 6'd38, K_AMP_A = 6'd39, K_CARET_A = 6'd40, K_PERCENT_A = 6'd41,
		K_STAR_A = 6'd42, K_SLASH_A = 6'd43, K_CHAR = 6'd46, K_INT = 6'd47,
		K_FLOAT = 6'd48, K_STR = 6'd49, K_IDENT = 6'd50
	} kind_t;

	typedef enum logic [2:0] {
		E_OK = 3'd0, E_UNKNOWN = 3'd1, E_CHAR = 3'd2, E_STRING = 3'd3, E_BASE = 3'd4,
		E_DIGIT = 3'd5, E_COMMENT = 3'd6, E_NEST = 3'd7
	} err_t;

	typedef enum logic [4:0] {
		M_IDLE, M_OP1, M_DOT2, M_HASH1, M_HASH2, M_LINE, M_BLK, M_BLK_H1, M_BLK_H2,
		M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_STR, M_STR_ESC, M_IDENT, M_DEC,
		M_BASED, M_NUM_DOT, M_FRAC
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]  tok_class;
		logic [2:0]  error_code;
		logic [63:0] int_value;
		logic [29:0] fraction_digits;
		logic [3:0]  fraction_count;
		logic        char_escaped;
		logic [31:0] text_offset;
		logic [31:0] text_length;
		logic [23:0] line_number;
		logic [15:0] column_number;
		logic        last_of_run;
	} out_beat_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b[7] ||
			b == 8'h5F;
	endfunction

	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd31;
		if (is_digit(b)) r = 5'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h37);
		return r;
	endfunction

	function automatic kind_t single_kind(input logic [7:0] b);
		kind_t k;
		case (b)
			8'h40: k = K_AT;
			8'h3B: k = K_SEMI;
			8'h2C: k = K_COMMA;
			8'h3A: k = K_COLON;
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h5B: k = K_LBRACKET;
			8'h5D: k = K_RBRACKET;
			8'h7B: k = K_LBRACE;
			8'h7D: k = K_RBRACE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t op_kind(input logic [7:0] b);
		kind_t k;
		case (b)
			8'h21: k = K_NOT;
			8'h2B: k = K_PLUS;
			8'h2D: k = K_MINUS;
			8'h2A: k = K_STAR;
			8'h2F: k = K_SLASH;
			8'h25: k = K_PERCENT;
			8'h5E: k = K_CARET;
			8'h7C: k = K_BAR;
			8'h26: k = K_AMP;
			8'h3C: k = K_LT;
			8'h3E: k = K_GT;
			8'h3D: k = K_ASSIGN;
			8'h2E: k = K_DOT;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(input kind_t first, input logic [7:0] b);
		kind_t k;
		k = K_NONE;
		if (b == 8'h3D) begin
			case (first)
				K_NOT: k = K_NEQ;
				K_PLUS: k = K_PLUS_A;
				K_MINUS: k = K_MINUS_A;
				K_STAR: k = K_STAR_A;
				K_SLASH: k = K_SLASH_A;
				K_PERCENT: k = K_PERCENT_A;
				K_CARET: k = K_CARET_A;
				K_BAR: k = K_BAR_A;
				K_AMP: k = K_AMP_A;
				K_LT: k = K_LTE;
				K_GT: k = K_GTE;
				K_ASSIGN: k = K_EQ;
				default: k = K_NONE;
			endcase
		end else if (b == 8'h3E && first == K_MINUS) k = K_ARROW;
		else if (b == 8'h3E && first == K_ASSIGN) k = K_FATARROW;
		else if (b == 8'h7C && first == K_BAR) k = K_LOR;
		else if (b == 8'h26 && first == K_AMP) k = K_LAND;
		return k;
	endfunction

endpackage

@@ sv/source_text_tokenizer.sv @@
// ============================================================================
// source_text_tokenizer: streaming lexer for source text
// Takes one source byte per beat and emits token beats.
// ============================================================================
// Usage: the input channel carries one byte per beat (in.text_byte), or an
// end marker (in.end_of_text) that flushes the pending token, reports an open
// comment or literal, and returns the scanner to its reset state.
// The output channel carries token beats; a byte gives zero, one or two of
// them, and last_of_run marks the final beat caused by one input beat.
// The input beat is registered, classified combinationally, and its results
// are written into a four-entry output queue, which offers them to the
// receiver. One byte is taken every cycle while the queue, after this cycle's
// pop, keeps two free slots, so throughput is one byte per cycle as long as
// the receiver drains the results as fast as they are produced. When the
// receiver stalls, the queue fills and in_stall rises; payloads stay steady
// while out_valid is high and stalled.
// Reset clears the scanner to line 1, column 1, offset 0, and empties the
// queue.
module source_text_tokenizer import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);
	logic      v_s1;
	in_beat_t  d_s1;
	logic      room;

	mode_t       mode_q;
	kind_t       pend_q;
	logic [63:0] acc_q;
	logic [4:0]  base_q;
	logic [29:0] frac_q;
	logic [3:0]  fcnt_q;
	logic        esc_q;
	logic [31:0] start_q, off_q;
	logic [23:0] line_q, tline_q, dline_q;
	logic [15:0] col_q, tcol_q, dcol_q;
	logic [3:0]  depth_q;

	mode_t       mode_n;
	kind_t       pend_n;
	logic [63:0] acc_n;
	logic [4:0]  base_n;
	logic [29:0] frac_n;
	logic [3:0]  fcnt_n;
	logic        esc_n;
	logic [31:0] start_n, off_n;
	logic [23:0] line_n, tline_n, dline_n;
	logic [15:0] col_n, tcol_n, dcol_n;
	logic [3:0]  depth_n;

	out_beat_t r0, r1;
	logic [1:0] nres;
	logic [7:0] b;
	logic [4:0] hv;
	logic [63:0] mul10, mulb;
	kind_t pk;

	assign in_stall = v_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (!in_stall) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) d_s1 <= in_data;
	end

	assign b = d_s1.text_byte;
	assign hv = hex_value(b);
	assign mul10 = acc_q * 64'd10 + {56'd0, b - 8'h30};
	assign mulb = acc_q * {59'd0, base_q} + {59'd0, hv};
	assign pk = pair_kind(pend_q, b);

	always_comb begin
		out_beat_t t;
		logic begin_b, mark;
		kind_t sk, ok;
		r0 = '0;
		r1 = '0;
		nres = 2'd0;
		mode_n = mode_q; pend_n = pend_q; acc_n = acc_q; base_n = base_q;
		frac_n = frac_q; fcnt_n = fcnt_q; esc_n = esc_q; start_n = start_q;
		off_n = off_q; line_n = line_q; col_n = col_q; tline_n = tline_q;
		tcol_n = tcol_q; dline_n = dline_q; dcol_n = dcol_q; depth_n = depth_q;
		begin_b = 1'b0;
		mark = 1'b0;
		t = '0;
		t.line_number = tline_q;
		t.column_number = tcol_q;
		sk = single_kind(b);
		ok = op_kind(b);
		if (d_s1.end_of_text) begin
			case (mode_q)
				M_OP1: t.tok_class = pend_q;
				M_DOT2: t.tok_class = K_RANGE;
				M_HASH1: t.tok_class = K_HASH;
				M_BLK, M_BLK_H1, M_BLK_H2: t.error_code = E_COMMENT;
				M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: t.error_code = E_CHAR;
				M_STR, M_STR_ESC: t.error_code = E_STRING;
				M_IDENT: begin
					t.tok_class = K_IDENT;
					t.text_offset = start_q;
					t.text_length = off_q - start_q;
				end
				M_DEC, M_BASED: begin
					t.tok_class = K_INT;
					t.int_value = acc_q;
				end
				M_NUM_DOT, M_FRAC: begin
					t.tok_class = K_FLOAT;
					t.int_value = acc_q;
					t.fraction_digits = frac_q;
					t.fraction_count = fcnt_q;
				end
				default: ;
			endcase
			if (mode_q != M_IDLE && mode_q != M_LINE && mode_q != M_HASH2) begin
				r0 = t;
				nres = 2'd1;
			end
			mode_n = M_IDLE; pend_n = K_NONE; acc_n = '0; base_n = 5'd10;
			frac_n = '0; fcnt_n = '0; esc_n = 1'b0; start_n = '0; off_n = '0;
			line_n = 24'd1; col_n = 16'd1; tline_n = 24'd1; tcol_n = 16'd1;
			dline_n = 24'd1; dcol_n = 16'd1; depth_n = '0;
		end else begin
			case (mode_q)
				M_OP1: begin
					if (pend_q == K_DOT) begin
						if (b == 8'h2E) mode_n = M_DOT2;
						else begin
							t.tok_class = K_DOT; r0 = t; nres = 2'd1; begin_b = 1'b1;
						end
					end else if (pk != K_NONE) begin
						t.tok_class = pk; r0 = t; nres = 2'd1; mode_n = M_IDLE;
					end else begin
						t.tok_class = pend_q; r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_DOT2: begin
					if (b == 8'h2E) begin
						t.tok_class = K_ELLIPSIS; r0 = t; nres = 2'd1; mode_n = M_IDLE;
					end else begin
						t.tok_class = K_RANGE; r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_HASH1: begin
					if (b == 8'h23) mode_n = M_HASH2;
					else begin
						t.tok_class = K_HASH; r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_HASH2: begin
					if (b == 8'h28) begin
						depth_n = 4'd1; mode_n = M_BLK;
					end else mode_n = (b == 8'h0A) ? M_IDLE : M_LINE;
				end
				M_LINE: if (b == 8'h0A) mode_n = M_IDLE;
				M_BLK: if (b == 8'h23) mode_n = M_BLK_H1;
				M_BLK_H1: mode_n = (b == 8'h23) ? M_BLK_H2 : M_BLK;
				M_BLK_H2: begin
					if (b != 8'h23) begin
						mode_n = M_BLK;
						if (b == 8'h28) begin
							if (depth_q >= 4'(MaxCommentDepth)) begin
								t.error_code = E_NEST;
								t.line_number = line_q;
								t.column_number = col_q;
								r0 = t; nres = 2'd1;
							end else depth_n = depth_q + 4'd1;
						end else if (b == 8'h29) begin
							if (depth_q <= 4'd1) begin
								depth_n = '0; mode_n = M_IDLE;
							end else depth_n = depth_q - 4'd1;
						end
					end
				end
				M_CHAR_OPEN: begin
					if (b == 8'h5C) begin
						esc_n = 1'b1; mode_n = M_CHAR_ESC;
					end else begin
						acc_n = {56'd0, b}; mode_n = M_CHAR_CLOSE;
					end
				end
				M_CHAR_ESC: begin
					acc_n = {56'd0, b}; mode_n = M_CHAR_CLOSE;
				end
				M_CHAR_CLOSE: begin
					if (b == 8'h27) begin
						t.tok_class = K_CHAR; t.int_value = acc_q; t.char_escaped = esc_q;
					end else t.error_code = E_CHAR;
					r0 = t; nres = 2'd1; mode_n = M_IDLE;
				end
				M_STR: begin
					if (b == 8'h5C) mode_n = M_STR_ESC;
					else if (b == 8'h22) begin
						t.tok_class = K_STR; t.text_offset = start_q;
						t.text_length = off_q - start_q;
						r0 = t; nres = 2'd1; mode_n = M_IDLE;
					end
				end
				M_STR_ESC: mode_n = M_STR;
				M_IDENT: begin
					if (!(is_alpha(b) || is_digit(b))) begin
						t.tok_class = K_IDENT; t.text_offset = start_q;
						t.text_length = off_q - start_q;
						r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_DEC: begin
					if (is_digit(b)) acc_n = mul10;
					else if (b == 8'h62) begin
						if (acc_q > 64'd16) begin
							t.error_code = E_BASE; r0 = t; nres = 2'd1; mode_n = M_IDLE;
						end else begin
							base_n = acc_q[4:0]; acc_n = '0; mode_n = M_BASED;
						end
					end else if (b == 8'h2E) begin
						dline_n = line_q; dcol_n = col_q; frac_n = '0; fcnt_n = '0;
						mode_n = M_NUM_DOT;
					end else begin
						t.tok_class = K_INT; t.int_value = acc_q;
						r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_BASED: begin
					if (b == 8'h5F) ;
					else if (hv < 5'd16) begin
						if (hv >= base_q) begin
							t.error_code = E_DIGIT; t.int_value = {56'd0, b};
							r0 = t; nres = 2'd1; mode_n = M_IDLE;
						end else acc_n = mulb;
					end else if (b == 8'h2E) begin
						dline_n = line_q; dcol_n = col_q; frac_n = '0; fcnt_n = '0;
						mode_n = M_NUM_DOT;
					end else begin
						t.tok_class = K_INT; t.int_value = acc_q;
						r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				M_NUM_DOT, M_FRAC: begin
					if (is_digit(b)) begin
						if (fcnt_q < 4'(FractionDigitsKept)) begin
							frac_n = 30'(frac_q * 30'd10 + {22'd0, b - 8'h30});
							fcnt_n = fcnt_q + 4'd1;
						end
						mode_n = M_FRAC;
					end else if (mode_q == M_NUM_DOT && b == 8'h2E) begin
						t.tok_class = K_INT; t.int_value = acc_q; r0 = t; nres = 2'd1;
						tline_n = dline_q; tcol_n = dcol_q; mode_n = M_DOT2;
					end else begin
						t.tok_class = K_FLOAT; t.int_value = acc_q;
						t.fraction_digits = frac_q; t.fraction_count = fcnt_q;
						r0 = t; nres = 2'd1; begin_b = 1'b1;
					end
				end
				default: begin_b = 1'b1;
			endcase
			if (begin_b) begin
				mode_n = M_IDLE;
				if (!(b == 8'h20 || b == 8'h09 || b == 8'h0A)) begin
					mark = 1'b1;
					t = '0;
					t.line_number = line_q;
					t.column_number = col_q;
					if (sk != K_NONE) t.tok_class = sk;
					else if (ok != K_NONE) begin
						pend_n = ok; mode_n = M_OP1;
					end else if (b == 8'h23) mode_n = M_HASH1;
					else if (b == 8'h27) begin
						esc_n = 1'b0; mode_n = M_CHAR_OPEN;
					end else if (b == 8'h22) mode_n = M_STR;
					else if (is_alpha(b)) mode_n = M_IDENT;
					else if (is_digit(b)) begin
						acc_n = {56'd0, b - 8'h30}; base_n = 5'd10; mode_n = M_DEC;
					end else begin
						t.error_code = E_UNKNOWN; t.int_value = {56'd0, b};
					end
					if (sk != K_NONE || t.error_code == E_UNKNOWN) begin
						if (nres == 2'd0) begin
							r0 = t; nres = 2'd1;
						end else begin
							r1 = t; nres = 2'd2;
						end
					end
				end
			end
			if (mark) begin
				tline_n = line_q; tcol_n = col_q;
				start_n = (b == 8'h22) ? off_q + 32'd1 : off_q;
			end
			off_n = off_q + 32'd1;
			if (b == 8'h0A) begin
				if (line_q < LineTop) line_n = line_q + 24'd1;
				col_n = 16'd1;
			end else if (col_q < ColTop) col_n = col_q + 16'd1;
		end
		if (nres == 2'd1) r0.last_of_run = 1'b1;
		if (nres == 2'd2) r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= K_NONE; acc_q <= '0; base_q <= 5'd10;
			frac_q <= '0; fcnt_q <= '0; esc_q <= 1'b0; start_q <= '0; off_q <= '0;
			line_q <= 24'd1; col_q <= 16'd1; tline_q <= 24'd1; tcol_q <= 16'd1;
			dline_q <= 24'd1; dcol_q <= 16'd1; depth_q <= '0;
		end else if (v_s1 && room) begin
			mode_q <= mode_n; pend_q <= pend_n; acc_q <= acc_n; base_q <= base_n;
			frac_q <= frac_n; fcnt_q <= fcnt_n; esc_q <= esc_n; start_q <= start_n;
			off_q <= off_n; line_q <= line_n; col_q <= col_n; tline_q <= tline_n;
			tcol_q <= tcol_n; dline_q <= dline_n; dcol_q <= dcol_n; depth_q <= depth_n;
		end
	end

	stt_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt ((v_s1 && room) ? nres : 2'd0),
		.push0    (r0),
		.push1    (r1),
		.room     (room),
		.valid    (out_valid),
		.stall    (out_stall),
		.data     (out_data)
	);

`ifndef NO_ASSERTIONS
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= 4'(MaxCommentDepth))
		else $error("comment depth above limit");
	a_block_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_BLK || mode_q == M_BLK_H1 || mode_q == M_BLK_H2) |-> depth_q != 4'd0)
		else $error("block comment with zero depth");
	a_no_push_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(mode_q))
		else $error("scanner advanced while stalled");
`endif

endmodule

@@ sv/stt_out_queue.sv @@
// ============================================================================
// stt_out_queue: result buffer for the tokenizer
// Holds up to four result beats; a byte yields at most two, and the scanner
// is stalled while fewer than two slots are free.
// ============================================================================
module stt_out_queue import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] push_cnt,
	input  out_beat_t push0,
	input  out_beat_t push1,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output out_beat_t data
);
	out_beat_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = valid && !stall;
	assign valid = cnt_q != 3'd0;
	assign data = mem_q[rd_q];
	assign room = (cnt_q - {2'b0, pop}) <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push_cnt;
			rd_q <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_q + 2'd1] <= push1;
	end

endmodule

@@ tb/source_text_tokenizer_tb.sv @@
// ============================================================================
// source_text_tokenizer_tb: self-checking bench for the source text tokenizer
// Streams directed and random source text through the block, predicts every
// token beat in a behavioral lexer and compares each output beat in order.
// ============================================================================
module source_text_tokenizer_tb;
	import stt_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b1;
	out_beat_t out_data;

	source_text_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	out_beat_t   token_queue[$];
	int          error_count = 0;
	int          bytes_sent = 0;
	int          tokens_seen = 0;
	int          idle_cycles = 0;
	int          rx_wait = 0;
	bit          hold_output = 1'b0;
	bit          timed_out = 1'b0;

	// Lexer state.
	mode_t       lx_mode;
	kind_t       lx_pending;
	logic [63:0] lx_value;
	logic [4:0]  lx_base;
	logic [29:0] lx_frac;
	logic [3:0]  lx_frac_cnt;
	logic        lx_esc;
	logic [31:0] lx_start;
	logic [31:0] lx_offset;
	logic [23:0] lx_line;
	logic [15:0] lx_col;
	logic [23:0] lx_tok_line;
	logic [15:0] lx_tok_col;
	logic [3:0]  lx_depth;
	logic [23:0] lx_dot_line;
	logic [15:0] lx_dot_col;
	logic [23:0] at_line;
	logic [15:0] at_col;
	logic [31:0] at_off;
	int          run_count;
	out_beat_t   run_beats[2];

	function automatic bit c_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit c_alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b >= 8'h80 || b == "_";
	endfunction

	function automatic logic [4:0] c_hex(logic [7:0] b);
		if (c_digit(b)) return 5'(b - "0");
		if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
		if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
		return 5'd31;
	endfunction

	function automatic kind_t c_single(logic [7:0] b);
		case (b)
			"@": return K_AT;
			";": return K_SEMI;
			",": return K_COMMA;
			":": return K_COLON;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"[": return K_LBRACKET;
			"]": return K_RBRACKET;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			default: return K_NONE;
		endcase
	endfunction

	function automatic kind_t c_op(logic [7:0] b);
		case (b)
			"!": return K_NOT;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"%": return K_PERCENT;
			"^": return K_CARET;
			"|": return K_BAR;
			"&": return K_AMP;
			"<": return K_LT;
			">": return K_GT;
			"=": return K_ASSIGN;
			".": return K_DOT;
			default: return K_NONE;
		endcase
	endfunction

	function automatic kind_t c_pair(kind_t f, logic [7:0] b);
		if (b == "=") begin
			case (f)
				K_NOT: return K_NEQ;
				K_PLUS: return K_PLUS_A;
				K_MINUS: return K_MINUS_A;
				K_STAR: return K_STAR_A;
				K_SLASH: return K_SLASH_A;
				K_PERCENT: return K_PERCENT_A;
				K_CARET: return K_CARET_A;
				K_BAR: return K_BAR_A;
				K_AMP: return K_AMP_A;
				K_LT: return K_LTE;
				K_GT: return K_GTE;
				K_ASSIGN: return K_EQ;
				default: return K_NONE;
			endcase
		end
		if (b == ">" && f == K_MINUS) return K_ARROW;
		if (b == ">" && f == K_ASSIGN) return K_FATARROW;
		if (b == "|" && f == K_BAR) return K_LOR;
		if (b == "&" && f == K_AMP) return K_LAND;
		return K_NONE;
	endfunction

	task automatic emit(kind_t k, err_t e, logic [63:0] iv, logic [29:0] fd, logic [3:0] fc,
			logic es, logic [31:0] off, logic [31:0] len, logic [23:0] ln, logic [15:0] cl);
		out_beat_t t;
		if (run_count >= 2) return;
		t = '0;
		t.tok_class = k;
		t.error_code = e;
		t.int_value = iv;
		t.fraction_digits = fd;
		t.fraction_count = fc;
		t.char_escaped = es;
		t.text_offset = off;
		t.text_length = len;
		t.line_number = ln;
		t.column_number = cl;
		run_beats[run_count] = t;
		run_count++;
	endtask

	task automatic emit_kind(kind_t k);
		emit(k, E_OK, 0, 0, 0, 0, 0, 0, lx_tok_line, lx_tok_col);
	endtask

	task automatic emit_err(err_t e, logic [63:0] iv);
		emit(K_NONE, e, iv, 0, 0, 0, 0, 0, lx_tok_line, lx_tok_col);
	endtask

	task automatic emit_float();
		emit(K_FLOAT, E_OK, lx_value, lx_frac, lx_frac_cnt, 0, 0, 0, lx_tok_line, lx_tok_col);
	endtask

	task automatic lexer_reset();
		lx_mode = M_IDLE;
		lx_pending = K_NONE;
		lx_value = '0;
		lx_base = 5'd10;
		lx_frac = '0;
		lx_frac_cnt = '0;
		lx_esc = 1'b0;
		lx_start = '0;
		lx_offset = '0;
		lx_line = 24'd1;
		lx_col = 16'd1;
		lx_tok_line = 24'd1;
		lx_tok_col = 16'd1;
		lx_depth = '0;
		lx_dot_line = 24'd1;
		lx_dot_col = 16'd1;
	endtask

	task automatic lex_begin(logic [7:0] b);
		kind_t k;
		lx_mode = M_IDLE;
		if (b == " " || b == 8'h09 || b == 8'h0A) return;
		lx_tok_line = at_line;
		lx_tok_col = at_col;
		lx_start = at_off;
		k = c_single(b);
		if (k != K_NONE) begin
			emit_kind(k);
			return;
		end
		k = c_op(b);
		if (k != K_NONE) begin
			lx_pending = k;
			lx_mode = M_OP1;
		end else if (b == "#") lx_mode = M_HASH1;
		else if (b == "'") begin
			lx_esc = 1'b0;
			lx_mode = M_CHAR_OPEN;
		end else if (b == "\"") begin
			lx_start = at_off + 1;
			lx_mode = M_STR;
		end else if (c_alpha(b)) lx_mode = M_IDENT;
		else if (c_digit(b)) begin
			lx_value = 64'(b - "0");
			lx_base = 5'd10;
			lx_mode = M_DEC;
		end else emit_err(E_UNKNOWN, 64'(b));
	endtask

	task automatic lex_dot();
		lx_dot_line = at_line;
		lx_dot_col = at_col;
		lx_frac = '0;
		lx_frac_cnt = '0;
		lx_mode = M_NUM_DOT;
	endtask

	task automatic lex_frac(logic [7:0] b);
		if (lx_frac_cnt < FractionDigitsKept) begin
			lx_frac = 30'(lx_frac * 10 + (b - "0"));
			lx_frac_cnt++;
		end
	endtask

	task automatic lex_scan(logic [7:0] b);
		kind_t k;
		logic [4:0] d;
		case (lx_mode)
			M_OP1: begin
				if (lx_pending == K_DOT) begin
					if (b == ".") lx_mode = M_DOT2;
					else begin
						emit_kind(K_DOT);
						lex_begin(b);
					end
				end else begin
					k = c_pair(lx_pending, b);
					if (k != K_NONE) begin
						emit_kind(k);
						lx_mode = M_IDLE;
					end else begin
						emit_kind(lx_pending);
						lex_begin(b);
					end
				end
			end
			M_DOT2: begin
				if (b == ".") begin
					emit_kind(K_ELLIPSIS);
					lx_mode = M_IDLE;
				end else begin
					emit_kind(K_RANGE);
					lex_begin(b);
				end
			end
			M_HASH1: begin
				if (b == "#") lx_mode = M_HASH2;
				else begin
					emit_kind(K_HASH);
					lex_begin(b);
				end
			end
			M_HASH2: begin
				if (b == "(") begin
					lx_depth = 4'd1;
					lx_mode = M_BLK;
				end else lx_mode = (b == 8'h0A) ? M_IDLE : M_LINE;
			end
			M_LINE: if (b == 8'h0A) lx_mode = M_IDLE;
			M_BLK: if (b == "#") lx_mode = M_BLK_H1;
			M_BLK_H1: lx_mode = (b == "#") ? M_BLK_H2 : M_BLK;
			M_BLK_H2: begin
				if (b != "#") begin
					lx_mode = M_BLK;
					if (b == "(") begin
						if (lx_depth >= MaxCommentDepth)
							emit(K_NONE, E_NEST, 0, 0, 0, 0, 0, 0, at_line, at_col);
						else lx_depth++;
					end else if (b == ")") begin
						if (lx_depth > 0) lx_depth--;
						if (lx_depth == 0) lx_mode = M_IDLE;
					end
				end
			end
			M_CHAR_OPEN: begin
				if (b == "\\") begin
					lx_esc = 1'b1;
					lx_mode = M_CHAR_ESC;
				end else begin
					lx_value = 64'(b);
					lx_mode = M_CHAR_CLOSE;
				end
			end
			M_CHAR_ESC: begin
				lx_value = 64'(b);
				lx_mode = M_CHAR_CLOSE;
			end
			M_CHAR_CLOSE: begin
				if (b == "'")
					emit(K_CHAR, E_OK, lx_value, 0, 0, lx_esc, 0, 0, lx_tok_line, lx_tok_col);
				else emit_err(E_CHAR, 0);
				lx_mode = M_IDLE;
			end
			M_STR: begin
				if (b == "\\") lx_mode = M_STR_ESC;
				else if (b == "\"") begin
					emit(K_STR, E_OK, 0, 0, 0, 0, lx_start, at_off - lx_start,
						lx_tok_line, lx_tok_col);
					lx_mode = M_IDLE;
				end
			end
			M_STR_ESC: lx_mode = M_STR;
			M_IDENT: begin
				if (!(c_alpha(b) || c_digit(b))) begin
					emit(K_IDENT, E_OK, 0, 0, 0, 0, lx_start, at_off - lx_start,
						lx_tok_line, lx_tok_col);
					lex_begin(b);
				end
			end
			M_DEC: begin
				if (c_digit(b)) lx_value = lx_value * 10 + 64'(b - "0");
				else if (b == "b") begin
					if (lx_value > 16) begin
						emit_err(E_BASE, 0);
						lx_mode = M_IDLE;
					end else begin
						lx_base = 5'(lx_value);
						lx_value = '0;
						lx_mode = M_BASED;
					end
				end else if (b == ".") lex_dot();
				else begin
					emit_kind(K_INT);
					run_beats[run_count - 1].int_value = lx_value;
					lex_begin(b);
				end
			end
			M_BASED: begin
				if (b != "_") begin
					d = c_hex(b);
					if (d < 16) begin
						if (d >= lx_base) begin
							emit_err(E_DIGIT, 64'(b));
							lx_mode = M_IDLE;
						end else lx_value = lx_value * 64'(lx_base) + 64'(d);
					end else if (b == ".") lex_dot();
					else begin
						emit(K_INT, E_OK, lx_value, 0, 0, 0, 0, 0, lx_tok_line, lx_tok_col);
						lex_begin(b);
					end
				end
			end
			M_NUM_DOT: begin
				if (c_digit(b)) begin
					lex_frac(b);
					lx_mode = M_FRAC;
				end else if (b == ".") begin
					emit(K_INT, E_OK, lx_value, 0, 0, 0, 0, 0, lx_tok_line, lx_tok_col);
					lx_tok_line = lx_dot_line;
					lx_tok_col = lx_dot_col;
					lx_mode = M_DOT2;
				end else begin
					emit_float();
					lex_begin(b);
				end
			end
			M_FRAC: begin
				if (c_digit(b)) lex_frac(b);
				else begin
					emit_float();
					lex_begin(b);
				end
			end
			default: lex_begin(b);
		endcase
	endtask

	task automatic lex_flush();
		case (lx_mode)
			M_OP1: emit_kind(lx_pending);
			M_DOT2: emit_kind(K_RANGE);
			M_HASH1: emit_kind(K_HASH);
			M_BLK, M_BLK_H1, M_BLK_H2: emit_err(E_COMMENT, 0);
			M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: emit_err(E_CHAR, 0);
			M_STR, M_STR_ESC: emit_err(E_STRING, 0);
			M_IDENT: emit(K_IDENT, E_OK, 0, 0, 0, 0, lx_start, lx_offset - lx_start,
				lx_tok_line, lx_tok_col);
			M_DEC, M_BASED: emit(K_INT, E_OK, lx_value, 0, 0, 0, 0, 0,
				lx_tok_line, lx_tok_col);
			M_NUM_DOT, M_FRAC: emit_float();
			default: ;
		endcase
	endtask

	task automatic predict_tokens(in_beat_t item);
		run_count = 0;
		if (item.end_of_text) begin
			lex_flush();
			lexer_reset();
		end else begin
			at_line = lx_line;
			at_col = lx_col;
			at_off = lx_offset;
			lex_scan(item.text_byte);
			lx_offset++;
			if (item.text_byte == 8'h0A) begin
				if (lx_line < LineTop) lx_line++;
				lx_col = 16'd1;
			end else if (lx_col < ColTop) lx_col++;
		end
		if (run_count > 0) run_beats[run_count - 1].last_of_run = 1'b1;
		for (int i = 0; i < run_count; i++) token_queue.push_back(run_beats[i]);
	endtask

	// Valid stays high after a beat is taken so that the next beat can follow
	// back to back; it drops only before an idle gap or at release_input.
	task automatic send_byte(logic [7:0] b, bit eot = 1'b0);
		in_beat_t item;
		int gap;
		item.text_byte = b;
		item.end_of_text = eot;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_tokens(item);
		bytes_sent++;
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on token %0d: %s got %0h expected %0h", tokens_seen, what, got, want);
		error_count++;
	endtask

	task automatic wait_drain();
		release_input();
		while (token_queue.size() != 0 && !timed_out) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			out_beat_t w;
			if (token_queue.size() == 0) begin
				report("unexpected beat of kind", out_data.tok_class, 0);
			end else begin
				w = token_queue.pop_front();
				if (out_data.tok_class != w.tok_class)
					report("kind", out_data.tok_class, w.tok_class);
				if (out_data.error_code != w.error_code)
					report("error", out_data.error_code, w.error_code);
				if (out_data.int_value != w.int_value)
					report("value", out_data.int_value, w.int_value);
				if (out_data.fraction_digits != w.fraction_digits)
					report("fraction", out_data.fraction_digits, w.fraction_digits);
				if (out_data.fraction_count != w.fraction_count)
					report("fraction count", out_data.fraction_count, w.fraction_count);
				if (out_data.char_escaped != w.char_escaped)
					report("escaped", out_data.char_escaped, w.char_escaped);
				if (out_data.text_offset != w.text_offset)
					report("offset", out_data.text_offset, w.text_offset);
				if (out_data.text_length != w.text_length)
					report("length", out_data.text_length, w.text_length);
				if (out_data.line_number != w.line_number)
					report("line", out_data.line_number, w.line_number);
				if (out_data.column_number != w.column_number)
					report("column", out_data.column_number, w.column_number);
				if (out_data.last_of_run != w.last_of_run)
					report("last", out_data.last_of_run, w.last_of_run);
			end
			tokens_seen++;
		end
	end

	// After each taken beat the receiver draws how many cycles it waits.
	always @(posedge clk) begin
		if (hold_output) out_stall <= 1'b1;
		else if (out_valid && !out_stall) begin
			rx_wait = $urandom_range(0, 4);
			out_stall <= (rx_wait != 0);
		end else if (rx_wait > 1) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			rx_wait = 0;
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("source_text_tokenizer test failed");
			timed_out = 1'b1;
			$finish;
		end
	end

	task automatic test_operators();
		send_text("@#,:.;!()[]{}+-*/^%&| .. ... -> => < <= > >= == != = ");
		send_text("+= -= |= &= ^= %= *= /= || && ");
		send_byte(0, 1'b1);
	endtask

	task automatic test_literals();
		send_text("'a' '\\n' 'ab \"s\\\"t\" _id9 0 18446744073709551616 ");
		send_text("16bFf_0 2b102 17b1 0b0 1b0 3.1415926535 7. 5..3 2b1.5 9...");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0D);
		send_text("\n## note\n##(a ##(b##) c##) x\"open");
		send_byte(0, 1'b1);
		send_text("'");
		send_byte(0, 1'b1);
		send_text("##(");
		repeat (16) send_text("##(");
		send_byte(0, 1'b1);
		send_byte(0, 1'b1);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_output = 1'b1;
				repeat (60) @(posedge clk);
				hold_output = 1'b0;
			end
			begin
				send_text("a+b-c;d,e:f[g]h{i}j@k");
				release_input();
			end
		join
		send_byte(0, 1'b1);
	endtask

	task automatic test_random();
		string pieces[16] = '{"abc", "x_1", "42", "12.5", "16bA_f", "8b17", "..", "->",
			"'q'", "\"st\\\"r\"", "##c\n", "##(z##)", "+=", "<=", "&&", "\n"};
		while (bytes_sent < 750) begin
			case ($urandom_range(0, 9))
				0, 1: send_byte(8'($urandom));
				2: send_byte(0, 1'b1);
				default: begin
					send_text(pieces[$urandom_range(0, 15)]);
					if ($urandom_range(0, 1)) send_byte(" ");
				end
			endcase
		end
		send_byte(0, 1'b1);
	endtask

	initial begin
		lexer_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_literals();
		test_backpressure();
		test_random();
		wait_drain();
		$display("sent %0d bytes and checked %0d token beats", bytes_sent, tokens_seen);
		$display("covered operators, literals, comments, errors and output stalls");
		if (error_count == 0 && token_queue.size() == 0)
			$display("source_text_tokenizer test passed");
		else
			$display("source_text_tokenizer test failed");
		$finish;
	end

endmodule
